@@ rtl/core/brp_pkg.sv @@
// shared constants and controller/datapath types for the bitmap tile rotator
package brp_pkg;

  localparam int TILE_SIZE      = 44;
  localparam int COEF_FRAC_BITS = 14;

  localparam int COORD_W   = 6;
  localparam int COEF_W    = 16;
  localparam int DEPTH     = TILE_SIZE * TILE_SIZE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int OFF_W     = COORD_W + 2;
  localparam int PROD_W    = COEF_W + OFF_W;
  localparam int ACC_W     = ((PROD_W > COEF_FRAC_BITS + 8) ? PROD_W : COEF_FRAC_BITS + 8) + 2;
  localparam int SHIFT     = COEF_FRAC_BITS + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(TILE_SIZE + 1) << COEF_FRAC_BITS;

  localparam logic signed [COEF_W-1:0] COS_RESET = 16'sd15391;
  localparam logic signed [COEF_W-1:0] SIN_RESET = -16'sd5618;

  localparam logic [CFG_IDX_W-1:0] REG_COS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRUNE = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int NUM_SAMPLES = 5;
  localparam int SIDX_W      = 3;
  localparam logic [SIDX_W-1:0] SAMP_CENTRE = 3'd0;
  localparam logic [SIDX_W-1:0] SAMP_LEFT   = 3'd1;
  localparam logic [SIDX_W-1:0] SAMP_RIGHT  = 3'd2;
  localparam logic [SIDX_W-1:0] SAMP_UP     = 3'd3;
  localparam logic [SIDX_W-1:0] SAMP_DOWN   = 3'd4;

  typedef struct packed {
    logic              clear;
    logic              load;
    logic              mul_a;
    logic              mul_b;
    logic              sample;
    logic [SIDX_W-1:0] sample_idx;
    logic              push;
  } brp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } brp_status_t;

endpackage

@@ rtl/core/brp_if.sv @@
// valid/ready channels: pixel items in, result pixels out, register writes
interface brp_item_if import brp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic               src_black;

  modport source(output valid, kind, x_coord, y_coord, src_black, input ready);
  modport sink(input valid, kind, x_coord, y_coord, src_black, output ready);
endinterface

interface brp_pixel_if ();
  logic valid;
  logic ready;
  logic pixel_black;

  modport source(output valid, pixel_black, input ready);
  modport sink(input valid, pixel_black, output ready);
endinterface

interface brp_cfg_if import brp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/brp_ctrl.sv @@
// sequencer: clear sweep, item intake, multiply steps, five samples, result push
module brp_ctrl import brp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_ready,
  input  brp_status_t status,
  output brp_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MUL_A  = 3'd2;
  localparam logic [2:0] S_MUL_B  = 3'd3;
  localparam logic [2:0] S_SAMPLE = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state, state_next;
  logic [SIDX_W-1:0] samp_cnt, samp_cnt_next;

  always_comb begin
    state_next    = state;
    samp_cnt_next = samp_cnt;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_kind == KIND_QUERY) begin
            state_next = S_MUL_A;
          end
        end
      end
      S_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b     = 1'b1;
        samp_cnt_next = SAMP_CENTRE;
        state_next    = S_SAMPLE;
      end
      S_SAMPLE: begin
        cmd.sample     = 1'b1;
        cmd.sample_idx = samp_cnt;
        samp_cnt_next  = samp_cnt + 1'b1;
        if (samp_cnt == SIDX_W'(NUM_SAMPLES - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read word folds in on this edge
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      samp_cnt <= '0;
    end else begin
      state    <= state_next;
      samp_cnt <= samp_cnt_next;
    end
  end

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_kind == KIND_QUERY) |=> state == S_MUL_A)
    else $error("query accepted without starting the multiply step");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SAMPLE) |-> samp_cnt < SIDX_W'(NUM_SAMPLES))
    else $error("sample counter ran past the last neighbour");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> status.out_free)
    else $error("result pushed over an untaken word");

endmodule

@@ rtl/core/brp_datapath.sv @@
// config registers, bit memory, rotation arithmetic, sample fold and result register
module brp_datapath import brp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  brp_cmd_t             cmd,
  output brp_status_t          status,
  input  logic                 in_kind,
  input  logic [COORD_W-1:0]   in_x,
  input  logic [COORD_W-1:0]   in_y,
  input  logic                 in_src,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_pixel
);

  logic signed [COEF_W-1:0] cos_r, sin_r;
  logic                     prune_r;

  logic [COORD_W-1:0]       x_r, y_r;
  logic                     in_tile_r;
  logic signed [OFF_W-1:0]  ox2, oy2;
  logic signed [PROD_W-1:0] mul_xc, mul_xs, mul_yc, mul_ys;
  logic signed [PROD_W-1:0] pxc, pxs;
  logic signed [ACC_W-1:0]  ax_base, ay_base;
  logic signed [ACC_W-1:0]  c2, s2, dx, dy, sax, say, hx, hy;
  logic                     samp_use, ok_x, ok_y, samp_ok;
  logic [COORD_W-1:0]       cx, cy;
  logic [ADDR_W-1:0]        samp_addr;

  logic                     mem [DEPTH];
  logic                     rd_data, rd_pend, rd_ok;
  logic [SIDX_W-1:0]        rd_idx;
  logic                     centre_r, any_r;

  logic [ADDR_W-1:0]        clr_addr;
  logic                     in_fits, mem_we, mem_wdata;
  logic [ADDR_W-1:0]        mem_waddr, in_addr;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_r   <= COS_RESET;
      sin_r   <= SIN_RESET;
      prune_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COS:   cos_r   <= cfg_data;
        REG_SIN:   sin_r   <= cfg_data;
        REG_PRUNE: prune_r <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  assign in_fits = ({1'b0, in_x} < (COORD_W + 1)'(TILE_SIZE)) &&
                   ({1'b0, in_y} < (COORD_W + 1)'(TILE_SIZE));
  assign in_addr = ADDR_W'(in_y) * ADDR_W'(TILE_SIZE) + ADDR_W'(in_x);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r       <= in_x;
      y_r       <= in_y;
      in_tile_r <= in_fits;
    end
  end

  // half-pixel offsets from the centre
  assign ox2 = $signed({1'b0, x_r, 1'b0}) - OFF_W'(TILE_SIZE);
  assign oy2 = $signed({1'b0, y_r, 1'b0}) - OFF_W'(TILE_SIZE);

  assign mul_xc = ox2 * cos_r;
  assign mul_xs = ox2 * sin_r;
  assign mul_yc = oy2 * cos_r;
  assign mul_ys = oy2 * sin_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      pxc <= mul_xc;
      pxs <= mul_xs;
    end
    if (cmd.mul_b) begin
      ax_base <= ACC_W'(pxc) + ACC_W'(mul_ys) + BIAS;
      ay_base <= ACC_W'(mul_yc) - ACC_W'(pxs) + BIAS;
    end
  end

  // a neighbour moves the half-pixel offset by two
  assign c2 = ACC_W'(cos_r) + ACC_W'(cos_r);
  assign s2 = ACC_W'(sin_r) + ACC_W'(sin_r);

  always_comb begin
    case (cmd.sample_idx)
      SAMP_CENTRE: begin
        dx = '0;  dy = '0;  samp_use = in_tile_r;
      end
      SAMP_LEFT: begin
        dx = -c2; dy = s2;  samp_use = (x_r != '0);
      end
      SAMP_RIGHT: begin
        dx = c2;  dy = -s2; samp_use = (x_r != COORD_W'(TILE_SIZE - 1));
      end
      SAMP_UP: begin
        dx = -s2; dy = -c2; samp_use = (y_r != '0);
      end
      SAMP_DOWN: begin
        dx = s2;  dy = c2;  samp_use = (y_r != COORD_W'(TILE_SIZE - 1));
      end
      default: begin
        dx = '0;  dy = '0;  samp_use = 1'b0;
      end
    endcase
  end

  // truncate toward zero; anything in (-1,0) lands on coordinate zero
  always_comb begin
    sax  = ax_base + dx;
    say  = ay_base + dy;
    hx   = sax >>> SHIFT;
    hy   = say >>> SHIFT;
    ok_x = sax[ACC_W-1] ? (hx == '1 && sax[SHIFT-1:0] != '0)
                        : (hx < ACC_W'(TILE_SIZE));
    ok_y = say[ACC_W-1] ? (hy == '1 && say[SHIFT-1:0] != '0)
                        : (hy < ACC_W'(TILE_SIZE));
    cx   = sax[ACC_W-1] ? '0 : hx[COORD_W-1:0];
    cy   = say[ACC_W-1] ? '0 : hy[COORD_W-1:0];
    samp_ok   = samp_use && ok_x && ok_y;
    samp_addr = ADDR_W'(cy) * ADDR_W'(TILE_SIZE) + ADDR_W'(cx);
  end

  // bit memory: clear sweep after reset, then pixel loads
  assign mem_we    = cmd.clear || (cmd.load && in_kind == KIND_WRITE && in_fits);
  assign mem_waddr = cmd.clear ? clr_addr : in_addr;
  assign mem_wdata = cmd.clear ? 1'b0 : in_src;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.sample) begin
      rd_data <= mem[samp_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign status.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      rd_ok  <= samp_ok;
      rd_idx <= cmd.sample_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      centre_r <= 1'b0;
      any_r    <= 1'b0;
    end else if (rd_pend) begin
      if (rd_idx == SAMP_CENTRE) begin
        centre_r <= rd_ok && rd_data;
      end else begin
        any_r <= any_r || (rd_ok && rd_data);
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_pixel <= in_tile_r && centre_r && (!prune_r || any_r);
    end
  end

  assign status.out_free = !out_valid || out_ready;

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.sample && samp_ok) |-> samp_addr < ADDR_W'(DEPTH))
    else $error("in-tile sample mapped outside the bit memory");

  a_clear_no_load: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !cmd.load)
    else $error("pixel load during the clear sweep");

endmodule

@@ rtl/core/bitmap_tile_rotate_and_prune.sv @@
// top level: nearest-neighbour rotation of a one-bit tile with isolated-pixel pruning
//
//   channel   dir   payload                                  handshake
//   items     in    kind, x_coord, y_coord, src_black        valid/ready
//   results   out   pixel_black                              valid/ready
//   cfg       in    index (cos, sin, prune), data            valid/ready
//
// a load word leaves the block ready for the next word; after a query is accepted
// the next word is taken only after two multiply steps, five samples (centre and four
// neighbours) read one per cycle from the single read port of the bit memory,
// a drain state, the result push and the return to the idle state.
// after reset the tile is cleared one pixel per cycle, all 1936 pixels, while items
// are held off; cfg is always ready. the result register lets a new word in
// while the last result waits; the push stalls while that result is untaken.
module bitmap_tile_rotate_and_prune import brp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  brp_item_if.sink   items,
  brp_cfg_if.sink    cfg,
  brp_pixel_if.source results
);

  brp_cmd_t    cmd;
  brp_status_t status;

  assign cfg.ready = 1'b1;

  brp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_kind  (items.kind),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  brp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_kind   (items.kind),
    .in_x      (items.x_coord),
    .in_y      (items.y_coord),
    .in_src    (items.src_black),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_pixel (results.pixel_black)
  );

endmodule

@@ tb/bitmap_tile_rotate_and_prune_test.sv @@
// self-checking testbench for the rotating and pruning bitmap tile block
`timescale 1ns / 1ps

module bitmap_tile_rotate_and_prune_test;
  import brp_pkg::*;

  // keeps its own copy of the tile and registers, expects one pixel per query
  class rotated_pixel_scoreboard;
    bit     src_tile [TILE_SIZE][TILE_SIZE]; // [row][column]
    longint cos_q;
    longint sin_q;
    bit     prune_on;
    bit     pending_pixels[$];
    int     failures;

    function new();
      cos_q = COS_RESET;
      sin_q = SIN_RESET;
      prune_on = 1'b1;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        REG_COS: begin
          cos_q = $signed(data);
        end
        REG_SIN: begin
          sin_q = $signed(data);
        end
        REG_PRUNE: begin
          prune_on = data[0];
        end
        default: begin
        end
      endcase
    endfunction

    // acc counts half pixels scaled by 2^COEF_FRAC_BITS; truncate toward zero
    function bit acc_to_index(longint acc, output int idx);
      longint unit;
      longint q;
      unit = longint'(1) << (COEF_FRAC_BITS + 1);
      idx = 0;
      if (acc < 0) begin
        if (-acc >= unit) return 1'b0;
        q = 0;
      end else begin
        q = acc / unit;
      end
      if (q >= TILE_SIZE) return 1'b0;
      idx = int'(q);
      return 1'b1;
    endfunction

    function bit sample_rotated(int x, int y);
      longint dx2;
      longint dy2;
      longint bias;
      longint ax;
      longint ay;
      int     sx;
      int     sy;
      dx2 = longint'(2 * x - TILE_SIZE);
      dy2 = longint'(2 * y - TILE_SIZE);
      bias = longint'(TILE_SIZE + 1) << COEF_FRAC_BITS;
      ax = dx2 * cos_q + dy2 * sin_q + bias;
      ay = dy2 * cos_q - dx2 * sin_q + bias;
      if (!acc_to_index(ax, sx)) return 1'b0;
      if (!acc_to_index(ay, sy)) return 1'b0;
      return src_tile[sy][sx];
    endfunction

    function void note_item(logic kind, logic [COORD_W-1:0] xc, logic [COORD_W-1:0] yc,
                            logic src);
      int x;
      int y;
      bit px;
      x = int'(xc);
      y = int'(yc);
      if (kind == KIND_WRITE) begin
        if (x < TILE_SIZE && y < TILE_SIZE) src_tile[y][x] = src;
        return;
      end
      px = 1'b0;
      if (x < TILE_SIZE && y < TILE_SIZE) begin
        px = sample_rotated(x, y);
        // isolated black pixel: cleared unless an in-tile neighbour is black
        if (px && prune_on)
          px = (x > 0 && sample_rotated(x - 1, y)) ||
               (x + 1 < TILE_SIZE && sample_rotated(x + 1, y)) ||
               (y > 0 && sample_rotated(x, y - 1)) ||
               (y + 1 < TILE_SIZE && sample_rotated(x, y + 1));
      end
      pending_pixels.push_back(px);
    endfunction

    function void check_pixel(logic got);
      bit want;
      if (pending_pixels.size() == 0) begin
        failures++;
        $error("pixel_black with no query pending: expected none, got %0b", got);
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want) begin
        failures++;
        $error("pixel_black mismatch: expected %0b, got %0b", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   out_of_reset;
  bit   tx_steady;
  bit   rx_steady;
  int   hold_results;

  rotated_pixel_scoreboard board;

  brp_item_if  items_ch ();
  brp_pixel_if pixel_ch ();
  brp_cfg_if   cfg_ch ();

  bitmap_tile_rotate_and_prune DUT (
    .clk(clk),
    .rst(rst),
    .items(items_ch),
    .cfg(cfg_ch),
    .results(pixel_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // everything accepted at an edge goes to the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) board.write_reg(cfg_ch.index, cfg_ch.data);
      if (items_ch.valid && items_ch.ready)
        board.note_item(items_ch.kind, items_ch.x_coord, items_ch.y_coord,
                        items_ch.src_black);
      if (pixel_ch.valid && pixel_ch.ready) board.check_pixel(pixel_ch.pixel_black);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    pixel_ch.ready <= 1'b0;
    wait (out_of_reset);
    forever begin
      if (hold_results > 0) begin
        stall = hold_results;
        hold_results = 0;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 13);
      end
      if (stall > 0) begin
        pixel_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pixel_ch.ready <= 1'b1;
      do @(posedge clk); while (!pixel_ch.valid);
    end
  end

  task automatic send_item(logic kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic src);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid     <= 1'b1;
    items_ch.kind      <= kind;
    items_ch.x_coord   <= x;
    items_ch.y_coord   <= y;
    items_ch.src_black <= src;
    do @(posedge clk); while (!items_ch.ready);
  endtask

  // wait for every pending pixel, then let a write still in flight settle
  task automatic drain_results();
    items_ch.valid <= 1'b0;
    while (board.pending_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic configure(logic [COEF_W-1:0] c, logic [COEF_W-1:0] s, logic p);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_COS;
    cfg_ch.data  <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_SIN;
    cfg_ch.data  <= s;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_PRUNE;
    cfg_ch.data  <= {{(COEF_W-1){1'b0}}, p};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // short strokes of pixels like glyph edges, queries, and a few off-tile words
  task automatic send_random_items(int count);
    int sent;
    int len;
    int x0;
    int y0;
    int tmp;
    int pick;
    bit vert;
    bit color;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = $urandom_range(1, 6);
        x0 = $urandom_range(0, TILE_SIZE - 1);
        y0 = $urandom_range(0, TILE_SIZE - 1);
        vert = 1'($urandom_range(0, 1));
        color = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < len; k++)
          send_item(KIND_WRITE, COORD_W'(vert ? x0 : x0 + k),
                    COORD_W'(vert ? y0 + k : y0), color);
        sent += len;
      end else if (pick < 42) begin
        x0 = $urandom_range(0, 63);
        y0 = $urandom_range(TILE_SIZE, 63);
        if ($urandom_range(0, 1)) begin
          tmp = x0;
          x0 = y0;
          y0 = tmp;
        end
        send_item(1'($urandom_range(0, 1)), COORD_W'(x0), COORD_W'(y0),
                  1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_item(KIND_QUERY, COORD_W'($urandom_range(0, TILE_SIZE - 1)),
                  COORD_W'($urandom_range(0, TILE_SIZE - 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [COEF_W-1:0] c;
    logic [COEF_W-1:0] s;
    logic              p;
    board = new();
    rst                <= 1'b1;
    items_ch.valid     <= 1'b0;
    items_ch.kind      <= KIND_WRITE;
    items_ch.x_coord   <= '0;
    items_ch.y_coord   <= '0;
    items_ch.src_black <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_COS;
    cfg_ch.data        <= '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_results = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    out_of_reset = 1'b1;

    // reset angle: empty tile, corners, a small block, off-tile words
    send_item(KIND_QUERY, 0, 0, 1);
    send_item(KIND_WRITE, 0, 0, 1);
    send_item(KIND_WRITE, 43, 43, 1);
    send_item(KIND_WRITE, 43, 0, 1);
    send_item(KIND_WRITE, 0, 43, 1);
    send_item(KIND_WRITE, 21, 21, 1);
    send_item(KIND_WRITE, 22, 21, 1);
    send_item(KIND_WRITE, 21, 22, 1);
    send_item(KIND_WRITE, 22, 22, 1);
    send_item(KIND_WRITE, 44, 0, 1);
    send_item(KIND_WRITE, 0, 63, 1);
    send_item(KIND_WRITE, 63, 63, 1);
    send_item(KIND_QUERY, 44, 0, 0);
    send_item(KIND_QUERY, 0, 63, 0);
    send_item(KIND_QUERY, 63, 63, 1);
    send_item(KIND_QUERY, 22, 22, 0);
    send_item(KIND_QUERY, 0, 0, 0);
    send_item(KIND_QUERY, 43, 43, 0);
    send_item(KIND_QUERY, 21, 21, 0);
    send_item(KIND_WRITE, 22, 22, 0);
    send_item(KIND_QUERY, 22, 22, 0);
    drain_results();

    // identity mapping: a lone black pixel is pruned only while pruning is on
    configure(16'h4000, 16'h0000, 1'b1);
    send_item(KIND_WRITE, 10, 30, 1);
    send_item(KIND_QUERY, 10, 30, 0);
    send_item(KIND_QUERY, 21, 21, 0);
    drain_results();
    configure(16'h4000, 16'h0000, 1'b0);
    send_item(KIND_QUERY, 10, 30, 0);

    for (int ph = 0; ph < 12; ph++) begin
      drain_results();
      case (ph)
        0:  begin c = 16'h4000; s = 16'h0000; p = 1'b1; end
        1:  begin c = 16'h4000; s = 16'h0000; p = 1'b0; end
        2:  begin c = 16'hC000; s = 16'h0000; p = 1'b1; end
        3:  begin c = 16'h0000; s = 16'h4000; p = 1'b0; end
        4:  begin c = 16'h0000; s = 16'hC000; p = 1'b1; end
        5:  begin c = 16'h7FFF; s = 16'h8000; p = 1'b1; end
        6:  begin c = 16'h8000; s = 16'h7FFF; p = 1'b0; end
        9:  begin
          c = COEF_W'($urandom);
          s = COEF_W'($urandom);
          p = 1'($urandom_range(0, 1));
        end
        11: begin c = COS_RESET; s = SIN_RESET; p = 1'b1; end
        default: begin
          c = COEF_W'(int'($urandom_range(0, 32768)) - 16384);
          s = COEF_W'(int'($urandom_range(0, 32768)) - 16384);
          p = 1'($urandom_range(0, 1));
        end
      endcase
      configure(c, s, p);
      tx_steady = (ph % 4 == 1);
      rx_steady = (ph % 3 == 2);
      if (ph == 5) begin
        // results held off while queries keep coming, so the input backs up
        hold_results = 400;
        tx_steady = 1'b1;
        for (int k = 0; k < 40; k++)
          send_item(KIND_QUERY, COORD_W'($urandom_range(0, TILE_SIZE - 1)),
                    COORD_W'($urandom_range(0, TILE_SIZE - 1)), 1'($urandom_range(0, 1)));
        tx_steady = 1'b0;
      end
      send_random_items(130);
    end
    drain_results();

    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
